/* rtl/mbsv_pkg.sv */
// ---------------------------------------------------------------------------
// mbsv_pkg
// Shared types and constants for the multibyte string validator: encoding
// codes, byte range limits and the per-string checking state.
// ---------------------------------------------------------------------------
package mbsv_pkg;

   typedef enum logic [2:0] {
      ENC_SINGLE  = 3'd0,
      ENC_UTF8    = 3'd1,
      ENC_EUCJP   = 3'd2,
      ENC_EUCKR   = 3'd3,
      ENC_EUCTW   = 3'd4,
      ENC_JOHAB   = 3'd5,
      ENC_BIG5    = 3'd6,
      ENC_GB18030 = 3'd7
   } encoding_type;

   localparam encoding_type RESET_ENCODING = ENC_UTF8;

   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] BYTE_ASCII_TOP = 8'h7F;
   localparam logic [7:0] EUC_LO         = 8'hA1;
   localparam logic [7:0] EUC_HI         = 8'hFE;
   localparam logic [7:0] EUC_KANA_HI    = 8'hDF;
   localparam logic [7:0] EUC_PLANE_HI   = 8'hA7;
   localparam logic [7:0] EUC_SS2        = 8'h8E;
   localparam logic [7:0] EUC_SS3        = 8'h8F;
   localparam logic [7:0] UTF8_LEAD2_LO  = 8'hC2;
   localparam logic [7:0] UTF8_LEAD2_HI  = 8'hDF;
   localparam logic [7:0] UTF8_LEAD3_LO  = 8'hE0;
   localparam logic [7:0] UTF8_LEAD3_HI  = 8'hEF;
   localparam logic [7:0] UTF8_LEAD_E0   = 8'hE0;
   localparam logic [7:0] UTF8_LEAD_ED   = 8'hED;
   localparam logic [7:0] UTF8_CONT_LO   = 8'h80;
   localparam logic [7:0] UTF8_CONT_HI   = 8'hBF;
   localparam logic [7:0] UTF8_E0_LO     = 8'hA0;
   localparam logic [7:0] UTF8_ED_HI     = 8'h9F;
   localparam logic [7:0] GB_DIGIT_LO    = 8'h30;
   localparam logic [7:0] GB_DIGIT_HI    = 8'h39;

   localparam int OFFSET_WIDTH = 16;

   typedef struct packed {
      logic [1:0]              bytes_left;
      logic [1:0]              char_position;
      logic [7:0]              lead_byte;
      logic [OFFSET_WIDTH-1:0] char_start;
      logic                    error_seen;
      logic [OFFSET_WIDTH-1:0] error_offset;
   } check_state_type;

   localparam check_state_type CHECK_STATE_CLEAR = '0;

   typedef struct packed {
      logic                    string_valid;
      logic [OFFSET_WIDTH-1:0] fail_offset;
   } verdict_type;

endpackage

/* rtl/mbsv_char_check.sv */
// ---------------------------------------------------------------------------
// mbsv_char_check
// Combinational byte checker: decodes lead bytes, checks trailing bytes and
// computes the next checking state and the verdict for the current byte.
// ---------------------------------------------------------------------------
module mbsv_char_check
   import mbsv_pkg::*;
(
   input  encoding_type            mode,
   input  check_state_type         state_cur,
   input  logic [OFFSET_WIDTH-1:0] byte_pos,
   input  logic [7:0]              data_byte,
   input  logic                    last_byte,
   output check_state_type         state_next,
   output verdict_type             verdict
);

   logic       lead_ok;
   logic [1:0] lead_need;
   logic       trail_ok;
   logic       is_digit;

   function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
                                     input logic [7:0] hi);
      return (b >= lo) && (b <= hi);
   endfunction

   always_comb begin
      lead_ok   = 1'b1;
      lead_need = 2'd0;
      if (data_byte == BYTE_ZERO) begin
         lead_ok = 1'b0;
      end else if (data_byte <= BYTE_ASCII_TOP) begin
         lead_need = 2'd0;
      end else begin
         case (mode)
            ENC_SINGLE: begin
               lead_need = 2'd0;
            end
            ENC_UTF8: begin
               if (in_range(data_byte, UTF8_LEAD2_LO, UTF8_LEAD2_HI)) begin
                  lead_need = 2'd1;
               end else if (in_range(data_byte, UTF8_LEAD3_LO, UTF8_LEAD3_HI)) begin
                  lead_need = 2'd2;
               end else begin
                  lead_ok = 1'b0;
               end
            end
            ENC_EUCJP: begin
               if (data_byte == EUC_SS2) begin
                  lead_need = 2'd1;
               end else if (data_byte == EUC_SS3) begin
                  lead_need = 2'd2;
               end else begin
                  lead_need = 2'd1;
                  lead_ok   = in_range(data_byte, EUC_LO, EUC_HI);
               end
            end
            ENC_EUCKR: begin
               lead_need = 2'd1;
               lead_ok   = in_range(data_byte, EUC_LO, EUC_HI);
            end
            ENC_EUCTW: begin
               if (data_byte == EUC_SS2) begin
                  lead_need = 2'd3;
               end else if (data_byte == EUC_SS3) begin
                  lead_ok = 1'b0;
               end else begin
                  lead_need = 2'd1;
               end
            end
            ENC_JOHAB: begin
               lead_need = (data_byte == EUC_SS3) ? 2'd2 : 2'd1;
            end
            default: begin
               lead_need = 2'd1;
            end
         endcase
      end
   end

   always_comb begin
      case (mode)
         ENC_UTF8: begin
            if (state_cur.char_position == 2'd1 && state_cur.lead_byte == UTF8_LEAD_E0) begin
               trail_ok = in_range(data_byte, UTF8_E0_LO, UTF8_CONT_HI);
            end else if (state_cur.char_position == 2'd1 &&
                         state_cur.lead_byte == UTF8_LEAD_ED) begin
               trail_ok = in_range(data_byte, UTF8_CONT_LO, UTF8_ED_HI);
            end else begin
               trail_ok = in_range(data_byte, UTF8_CONT_LO, UTF8_CONT_HI);
            end
         end
         ENC_EUCJP: begin
            if (state_cur.lead_byte == EUC_SS2) begin
               trail_ok = in_range(data_byte, EUC_LO, EUC_KANA_HI);
            end else begin
               trail_ok = in_range(data_byte, EUC_LO, EUC_HI);
            end
         end
         ENC_EUCKR, ENC_JOHAB: begin
            trail_ok = in_range(data_byte, EUC_LO, EUC_HI);
         end
         ENC_EUCTW: begin
            if (state_cur.lead_byte == EUC_SS2 && state_cur.char_position == 2'd1) begin
               trail_ok = in_range(data_byte, EUC_LO, EUC_PLANE_HI);
            end else begin
               trail_ok = in_range(data_byte, EUC_LO, EUC_HI);
            end
         end
         default: begin
            trail_ok = (data_byte != BYTE_ZERO);
         end
      endcase
   end

   assign is_digit = in_range(data_byte, GB_DIGIT_LO, GB_DIGIT_HI);

   always_comb begin
      state_next = state_cur;
      if (!state_cur.error_seen) begin
         if (state_cur.bytes_left == 2'd0) begin
            state_next.char_start    = byte_pos;
            state_next.lead_byte     = data_byte;
            state_next.char_position = 2'd1;
            if (!lead_ok) begin
               state_next.error_seen   = 1'b1;
               state_next.error_offset = byte_pos;
               state_next.bytes_left   = 2'd0;
            end else begin
               state_next.bytes_left = lead_need;
            end
         end else if (!trail_ok) begin
            state_next.error_seen   = 1'b1;
            state_next.error_offset = state_cur.char_start;
            state_next.bytes_left   = 2'd0;
         end else begin
            if (mode == ENC_GB18030 && state_cur.char_position == 2'd1) begin
               state_next.bytes_left = is_digit ? 2'd2 : 2'd0;
            end else begin
               state_next.bytes_left = state_cur.bytes_left - 2'd1;
            end
            state_next.char_position = state_cur.char_position + 2'd1;
         end
      end
      if (last_byte && !state_next.error_seen && state_next.bytes_left != 2'd0) begin
         state_next.error_seen   = 1'b1;
         state_next.error_offset = state_next.char_start;
         state_next.bytes_left   = 2'd0;
      end
      verdict.string_valid = !state_next.error_seen;
      verdict.fail_offset  = state_next.error_seen ? state_next.error_offset : '0;
   end

endmodule

/* rtl/multibyte_string_validator.sv */
// ---------------------------------------------------------------------------
// multibyte_string_validator
// Checks a byte stream against the selected multibyte encoding and reports
// the verdict for each string.
//
// The req channel carries one byte per transaction, with req_last_byte set on
// the final byte of a string. The rsp channel carries one transaction per
// string: rsp_string_valid and rsp_fail_offset, the offset of the first bad
// character. csr_write_enable writes csr_write_data into the encoding mode.
// The user must change the mode only while no string is in flight;
// the block does not enforce this. A byte is held in an input register and
// then checked into the result register, which takes a string's verdict as
// its last byte leaves the input register. One byte is accepted every cycle
// unless the receiver stalls; the state loops through the character checker.
// Reset empties both registers, clears the string state and selects UTF-8.
// If the receiver stalls, the verdict is held and the input register fills;
// req_ready then drops until the result is taken.
// Offsets saturate at the smaller of MAX_STRING_BYTES - 1 and 65535.
// ---------------------------------------------------------------------------
module multibyte_string_validator
   import mbsv_pkg::*;
#(
   parameter int unsigned MAX_STRING_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_string_valid,
   output logic [15:0] rsp_fail_offset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data
);

   localparam int unsigned CAP_FULL   = MAX_STRING_BYTES - 1;
   localparam int unsigned CAP_LIMIT  = (1 << OFFSET_WIDTH) - 1;
   localparam int unsigned CAP_VALUE  = (CAP_FULL > CAP_LIMIT) ? CAP_LIMIT : CAP_FULL;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_CAP = CAP_VALUE[OFFSET_WIDTH-1:0];

   encoding_type            mode_ff;
   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff;
   logic                    in_last_ff;
   check_state_type         state_ff, state_in;
   logic [OFFSET_WIDTH-1:0] count_ff, count_in;
   logic                    out_valid_ff, out_valid_in;
   verdict_type             out_ff;
   check_state_type         state_next;
   verdict_type             verdict;
   logic                    advance;
   logic                    consume;

   mbsv_char_check u_check (
      .mode       (mode_ff),
      .state_cur  (state_ff),
      .byte_pos   (count_ff),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_next (state_next),
      .verdict    (verdict)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign consume   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (consume) begin
         if (in_last_ff) begin
            state_in     = CHECK_STATE_CLEAR;
            count_in     = '0;
            out_valid_in = 1'b1;
         end else begin
            state_in = state_next;
            if (count_ff < OFFSET_CAP) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= RESET_ENCODING;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= CHECK_STATE_CLEAR;
         count_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= encoding_type'(csr_write_data);
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (consume && in_last_ff) begin
         out_ff <= verdict;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_string_valid = out_ff.string_valid;
   assign rsp_fail_offset  = out_ff.fail_offset;

endmodule

/* tb/sv/tb_multibyte_string_validator.sv */
// ----------------------------------------------------------------------------
// Multibyte string validator testbench
// Streams strings into the validator one byte per transaction under every
// encoding mode, predicts each string verdict from its own model of the
// encoding rules and compares every verdict transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multibyte_string_validator
   import mbsv_pkg::*;
;

   localparam int unsigned MAX_BYTES = 65536;
   localparam int unsigned OFFSET_CAP = (MAX_BYTES - 1 > 65535) ? 65535 : MAX_BYTES - 1;

   class string_verdict_book;
      encoding_type mode;
      int unsigned  cap;
      logic [1:0]   left;
      logic [1:0]   slot;
      logic [7:0]   lead;
      logic [15:0]  start;
      logic [15:0]  count;
      logic         bad;
      logic [15:0]  bad_at;
      verdict_type  verdicts_due[$];
      int           failures;

      function new(int unsigned cap_arg);
         cap = cap_arg;
         mode = RESET_ENCODING;
         failures = 0;
         clear_string();
      endfunction

      function void clear_string();
         left = 2'd0;
         slot = 2'd0;
         lead = 8'd0;
         start = 16'd0;
         count = 16'd0;
         bad = 1'b0;
         bad_at = 16'd0;
      endfunction

      function void mark_bad(logic [15:0] at);
         bad = 1'b1;
         bad_at = at;
         left = 2'd0;
      endfunction

      function bit between(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
         return b >= lo && b <= hi;
      endfunction

      function int lead_trail_count(encoding_type m, logic [7:0] b);
         if (b == BYTE_ZERO) return -1;
         if (b <= BYTE_ASCII_TOP) return 0;
         case (m)
            ENC_SINGLE: return 0;
            ENC_UTF8: begin
               if (between(b, UTF8_LEAD2_LO, UTF8_LEAD2_HI)) return 1;
               if (between(b, UTF8_LEAD3_LO, UTF8_LEAD3_HI)) return 2;
               return -1;
            end
            ENC_EUCJP: begin
               if (b == EUC_SS2) return 1;
               if (b == EUC_SS3) return 2;
               return between(b, EUC_LO, EUC_HI) ? 1 : -1;
            end
            ENC_EUCKR: return between(b, EUC_LO, EUC_HI) ? 1 : -1;
            ENC_EUCTW: begin
               if (b == EUC_SS2) return 3;
               if (b == EUC_SS3) return -1;
               return 1;
            end
            ENC_JOHAB: return (b == EUC_SS3) ? 2 : 1;
            default: return 1;
         endcase
      endfunction

      function bit trail_fits(encoding_type m, logic [7:0] ld, logic [1:0] at, logic [7:0] b);
         case (m)
            ENC_UTF8: begin
               if (at == 2'd1 && ld == UTF8_LEAD_E0) return between(b, UTF8_E0_LO, UTF8_CONT_HI);
               if (at == 2'd1 && ld == UTF8_LEAD_ED) return between(b, UTF8_CONT_LO, UTF8_ED_HI);
               return between(b, UTF8_CONT_LO, UTF8_CONT_HI);
            end
            ENC_EUCJP: begin
               if (ld == EUC_SS2) return between(b, EUC_LO, EUC_KANA_HI);
               return between(b, EUC_LO, EUC_HI);
            end
            ENC_EUCKR, ENC_JOHAB: return between(b, EUC_LO, EUC_HI);
            ENC_EUCTW: begin
               if (ld == EUC_SS2 && at == 2'd1) return between(b, EUC_LO, EUC_PLANE_HI);
               return between(b, EUC_LO, EUC_HI);
            end
            default: return b != BYTE_ZERO;
         endcase
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         int          need;
         verdict_type v;
         if (!bad) begin
            if (left == 2'd0) begin
               need = lead_trail_count(mode, b);
               start = count;
               lead = b;
               slot = 2'd1;
               if (need < 0) mark_bad(count);
               else left = 2'(need);
            end else if (!trail_fits(mode, lead, slot, b)) begin
               mark_bad(start);
            end else begin
               if (mode == ENC_GB18030 && slot == 2'd1)
                  left = between(b, GB_DIGIT_LO, GB_DIGIT_HI) ? 2'd2 : 2'd0;
               else
                  left = left - 2'd1;
               slot = slot + 2'd1;
            end
         end
         if (count < cap) count = count + 16'd1;
         if (last) begin
            if (!bad && left != 2'd0) mark_bad(start);
            v.string_valid = !bad;
            v.fail_offset = bad ? bad_at : 16'd0;
            verdicts_due.push_back(v);
            clear_string();
         end
      endfunction

      function void check_verdict(logic valid_bit, logic [15:0] offset);
         verdict_type v;
         if (verdicts_due.size() == 0) begin
            $error("unexpected verdict: string_valid=%0d fail_offset=%0d", valid_bit, offset);
            failures++;
            return;
         end
         v = verdicts_due.pop_front();
         if (valid_bit !== v.string_valid) begin
            $error("string_valid: expected %0d, actual %0d", v.string_valid, valid_bit);
            failures++;
         end
         if (offset !== v.fail_offset) begin
            $error("fail_offset: expected %0d, actual %0d", v.fail_offset, offset);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_string_valid;
   logic [15:0] rsp_fail_offset;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_write_data = 3'd0;

   string_verdict_book book = new(OFFSET_CAP);
   int req_idle = 28;
   int rsp_idle = 28;
   int hold_asks = 0;
   int bytes_sent = 0;

   multibyte_string_validator #(
      .MAX_STRING_BYTES(MAX_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_string_valid(rsp_string_valid),
      .rsp_fail_offset(rsp_fail_offset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi);
      return 8'($urandom_range(int'(hi), int'(lo)));
   endfunction

   function automatic void push_char(input encoding_type m, ref logic [7:0] s[$]);
      logic [7:0] ld;
      logic [7:0] t;
      if ($urandom_range(0, 3) == 0) begin
         s.push_back(pick(8'h01, BYTE_ASCII_TOP));
         return;
      end
      case (m)
         ENC_SINGLE: s.push_back(pick(8'h01, 8'hFF));
         ENC_UTF8: begin
            case ($urandom_range(0, 3))
               0: begin
                  s.push_back(pick(UTF8_LEAD2_LO, UTF8_LEAD2_HI));
                  s.push_back(pick(UTF8_CONT_LO, UTF8_CONT_HI));
               end
               1: begin
                  s.push_back(UTF8_LEAD_E0);
                  s.push_back(pick(UTF8_E0_LO, UTF8_CONT_HI));
                  s.push_back(pick(UTF8_CONT_LO, UTF8_CONT_HI));
               end
               default: begin
                  ld = pick(8'hE1, UTF8_LEAD3_HI);
                  s.push_back(ld);
                  s.push_back((ld == UTF8_LEAD_ED) ? pick(UTF8_CONT_LO, UTF8_ED_HI)
                                                   : pick(UTF8_CONT_LO, UTF8_CONT_HI));
                  s.push_back(pick(UTF8_CONT_LO, UTF8_CONT_HI));
               end
            endcase
         end
         ENC_EUCJP: begin
            case ($urandom_range(0, 2))
               0: begin
                  s.push_back(EUC_SS2);
                  s.push_back(pick(EUC_LO, EUC_KANA_HI));
               end
               1: begin
                  s.push_back(EUC_SS3);
                  s.push_back(pick(EUC_LO, EUC_HI));
                  s.push_back(pick(EUC_LO, EUC_HI));
               end
               default: begin
                  s.push_back(pick(EUC_LO, EUC_HI));
                  s.push_back(pick(EUC_LO, EUC_HI));
               end
            endcase
         end
         ENC_EUCKR: begin
            s.push_back(pick(EUC_LO, EUC_HI));
            s.push_back(pick(EUC_LO, EUC_HI));
         end
         ENC_EUCTW: begin
            if ($urandom_range(0, 2) == 0) begin
               s.push_back(EUC_SS2);
               s.push_back(pick(EUC_LO, EUC_PLANE_HI));
               s.push_back(pick(EUC_LO, EUC_HI));
               s.push_back(pick(EUC_LO, EUC_HI));
            end else begin
               ld = pick(8'h80, 8'hFF);
               if (ld == EUC_SS2 || ld == EUC_SS3) ld = EUC_LO;
               s.push_back(ld);
               s.push_back(pick(EUC_LO, EUC_HI));
            end
         end
         ENC_JOHAB: begin
            ld = ($urandom_range(0, 3) == 0) ? EUC_SS3 : pick(8'h80, 8'hFF);
            s.push_back(ld);
            s.push_back(pick(EUC_LO, EUC_HI));
            if (ld == EUC_SS3) s.push_back(pick(EUC_LO, EUC_HI));
         end
         ENC_BIG5: begin
            s.push_back(pick(8'h80, 8'hFF));
            s.push_back(pick(8'h01, 8'hFF));
         end
         default: begin
            s.push_back(pick(8'h80, 8'hFF));
            if ($urandom_range(0, 1) == 0) begin
               s.push_back(pick(GB_DIGIT_LO, GB_DIGIT_HI));
               s.push_back(pick(8'h01, 8'hFF));
               s.push_back(pick(8'h01, 8'hFF));
            end else begin
               t = pick(8'h01, 8'hFF);
               if (t >= GB_DIGIT_LO && t <= GB_DIGIT_HI) t = 8'h40;
               s.push_back(t);
            end
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (req_idle != 0 && $urandom_range(0, 99) < req_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      book.take_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_string(input logic [7:0] s[$]);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
   endtask

   task automatic send_random_string(input encoding_type m);
      logic [7:0] s[$];
      int         kind;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 4)) s.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) push_char(m, s);
         if (kind < 18) begin
            s[$urandom_range(0, s.size() - 1)] = 8'($urandom);
         end else if (kind < 22) begin
            s[$urandom_range(0, s.size() - 1)] = BYTE_ZERO;
         end else if (kind < 30) begin
            push_char(m, s);
            void'(s.pop_back());
            if (s.size() == 0) s.push_back(pick(8'h80, 8'hFF));
         end
      end
      send_string(s);
   endtask

   task automatic write_mode(input encoding_type m);
      req_valid <= 1'b0;
      while (book.verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book.mode = m;
   endtask

   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 120;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (rsp_idle == 0) || ($urandom_range(0, 99) >= rsp_idle);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) book.check_verdict(rsp_string_valid, rsp_fail_offset);
      end
   end

   initial begin
      logic [7:0]   s[$];
      encoding_type plan[10];
      int           stop;
      plan = '{ENC_SINGLE, ENC_GB18030, ENC_UTF8, ENC_EUCJP, ENC_EUCKR,
               ENC_EUCTW, ENC_JOHAB, ENC_BIG5, ENC_GB18030, ENC_SINGLE};
      plan[8] = encoding_type'($urandom_range(0, 7));
      plan[9] = encoding_type'($urandom_range(0, 7));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      s = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'hBF, 8'hED, 8'h9F, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
      send_string(s);
      s = '{8'hE0, 8'h9F, 8'h80};
      send_string(s);
      s = '{8'h41, 8'hED, 8'hA0};
      send_string(s);
      s = '{BYTE_ZERO};
      send_string(s);
      s = '{8'hFF, 8'hC3};
      send_string(s);
      s = '{8'hC3};
      send_string(s);
      send_byte(8'hE1, 1'b0);
      send_byte(8'h80, 1'b0);

      for (int p = 0; p < 10; p++) begin
         write_mode(plan[p]);
         req_idle = (p == 3) ? 0 : 28;
         rsp_idle = (p == 3) ? 0 : 28;
         if (p == 0) send_byte(8'h05, 1'b1);
         if (p == 5) hold_asks++;
         stop = bytes_sent + 115;
         while (bytes_sent < stop) send_random_string(plan[p]);
      end

      req_valid <= 1'b0;
      while (book.verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.verdicts_due.size() != 0) begin
         $error("%0d verdicts never arrived", book.verdicts_due.size());
         book.failures++;
      end
      if (book.failures == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mbsv_pkg.sv
rtl/mbsv_char_check.sv
rtl/multibyte_string_validator.sv
tb/sv/tb_multibyte_string_validator.sv
